[src/argbb_pkg.sv]
// ----------------------------------------------------------------------------
// argbb_pkg
// Shared types, widths and arithmetic helpers for the ARGB4444 over RGB565
// rectangle blender.
// ----------------------------------------------------------------------------
package argbb_pkg;

  localparam int PIX_W       = 16;
  localparam int IDX_W       = 24;
  localparam int STRIDE_W    = 12;
  localparam int POS_W       = 11;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int ALPHA_W     = 4;
  localparam int CHAN_W      = 6;
  localparam int SUM_W       = 10;
  localparam int MAX_DIM_DEF = 2048;

  // x / 15 == (x * 2185) >> 15 for every x below 1024
  localparam int          RECIP_W     = 12;
  localparam int          RECIP_SHIFT = 15;
  localparam int          PROD_W      = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_15 = 12'd2185;

  localparam logic [ALPHA_W-1:0] ALPHA_FULL = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_STRIDE = 3'd0,
    REG_DEST_LEFT   = 3'd1,
    REG_DEST_TOP    = 3'd2,
    REG_SRC_STRIDE  = 3'd3,
    REG_SRC_LEFT    = 3'd4,
    REG_SRC_TOP     = 3'd5,
    REG_RECT_WIDTH  = 3'd6,
    REG_RECT_HEIGHT = 3'd7
  } cfg_reg_t;

  // source weighted by alpha plus destination weighted by 15 - alpha
  function automatic logic [SUM_W-1:0] weigh(input logic [CHAN_W-1:0]  s,
                                             input logic [CHAN_W-1:0]  d,
                                             input logic [ALPHA_W-1:0] a);
    logic [SUM_W-1:0] ps;
    logic [SUM_W-1:0] pd;
    ps = SUM_W'(s) * SUM_W'(a);
    pd = SUM_W'(d) * SUM_W'(ALPHA_FULL - a);
    return ps + pd;
  endfunction

  function automatic logic [CHAN_W-1:0] div15(input logic [SUM_W-1:0] x);
    logic [PROD_W-1:0] p;
    p = PROD_W'(x) * PROD_W'(RECIP_15);
    return p[RECIP_SHIFT +: CHAN_W];
  endfunction

endpackage

[src/argb4444_rect_blend_onto_rgb565_top.sv]
// ----------------------------------------------------------------------------
// argb4444_rect_blend_onto_rgb565_top
// Blends a raster-ordered rectangle of ARGB4444 pixels onto RGB565 pixels
// and reports destination and source linear indexes per pixel.
// ----------------------------------------------------------------------------
// The block takes one source/destination pixel pair per clock unless the
// output stalls and returns one result per request, in order, via the first
// stage and output registers. The first stage forms the alpha-weighted
// channel sums and the rectangle row/column offsets; the second stage divides
// the sums by 15 with a reciprocal multiply and forms each index with one
// 12-bit stride multiply. Column and line counters advance on every accepted
// request and restart after the pixel flagged last. Configuration registers
// are written through the cfg channel, which is always ready; the user must
// write them only while no request is in flight, which the block does not
// enforce. A size of zero acts as one and a size above MAX_DIM-1 as MAX_DIM-1.
module argb4444_rect_blend_onto_rgb565_top #(
  parameter int MAX_DIM = argbb_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [argbb_pkg::PIX_W-1:0]      src_pixel,
  input  logic [argbb_pkg::PIX_W-1:0]      dest_pixel,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [argbb_pkg::PIX_W-1:0]      blended_pixel,
  output logic [argbb_pkg::IDX_W-1:0]      dest_index,
  output logic [argbb_pkg::IDX_W-1:0]      src_index,
  output logic                             last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [argbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [argbb_pkg::CFG_DATA_W-1:0] cfg_data
);

  import argbb_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);
  localparam int CMP_W = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
  localparam int ROW_W = CMP_W;
  localparam int MUL_W = ROW_W + STRIDE_W;
  localparam logic [CMP_W-1:0] SIZE_MAX = CMP_W'(MAX_DIM - 1);
  localparam logic [CMP_W-1:0] SIZE_ONE = CMP_W'(1);

  // configuration
  logic [STRIDE_W-1:0] dest_stride, src_stride;
  logic [POS_W-1:0]    dest_left, dest_top, src_left, src_top;
  logic [POS_W-1:0]    rect_width, rect_height;

  // position counters
  logic [CNT_W-1:0] column_count, column_count_next;
  logic [CNT_W-1:0] line_count, line_count_next;

  // first stage
  logic             s1_valid;
  logic [SUM_W-1:0] s1_sum_r, s1_sum_g, s1_sum_b;
  logic [ROW_W-1:0] s1_dest_row, s1_src_row;
  logic [ROW_W-1:0] s1_dest_col, s1_src_col;
  logic             s1_last;

  logic             in_acc, out_en, s1_adv;
  logic [CMP_W-1:0] w_ext, h_ext, w_eff, h_eff;
  logic             col_end, line_end;

  logic [ALPHA_W-1:0] alpha;
  logic [CHAN_W-1:0]  sr, sg, sb, dr, dg, db;

  logic [MUL_W-1:0]  dest_prod, src_prod;
  logic [CHAN_W-1:0] q_r, q_g, q_b;

  assign cfg_ready = 1'b1;

  assign out_en   = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_en;
  assign in_ready = !s1_valid || out_en;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dest_stride <= STRIDE_W'(1);
      dest_left   <= '0;
      dest_top    <= '0;
      src_stride  <= STRIDE_W'(1);
      src_left    <= '0;
      src_top     <= '0;
      rect_width  <= POS_W'(1);
      rect_height <= POS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_DEST_STRIDE: dest_stride <= cfg_data;
        REG_DEST_LEFT:   dest_left   <= cfg_data[POS_W-1:0];
        REG_DEST_TOP:    dest_top    <= cfg_data[POS_W-1:0];
        REG_SRC_STRIDE:  src_stride  <= cfg_data;
        REG_SRC_LEFT:    src_left    <= cfg_data[POS_W-1:0];
        REG_SRC_TOP:     src_top     <= cfg_data[POS_W-1:0];
        REG_RECT_WIDTH:  rect_width  <= cfg_data[POS_W-1:0];
        REG_RECT_HEIGHT: rect_height <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective rectangle size and position stepping
  always_comb begin
    w_ext = CMP_W'(rect_width);
    h_ext = CMP_W'(rect_height);
    if (w_ext == '0) begin
      w_eff = SIZE_ONE;
    end else if (w_ext > SIZE_MAX) begin
      w_eff = SIZE_MAX;
    end else begin
      w_eff = w_ext;
    end
    if (h_ext == '0) begin
      h_eff = SIZE_ONE;
    end else if (h_ext > SIZE_MAX) begin
      h_eff = SIZE_MAX;
    end else begin
      h_eff = h_ext;
    end
    col_end  = (CMP_W'(column_count) + SIZE_ONE) >= w_eff;
    line_end = (CMP_W'(line_count) + SIZE_ONE) >= h_eff;
    if (col_end) begin
      column_count_next = '0;
      line_count_next   = line_end ? '0 : line_count + CNT_W'(1);
    end else begin
      column_count_next = column_count + CNT_W'(1);
      line_count_next   = line_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      line_count   <= '0;
    end else if (in_acc) begin
      column_count <= column_count_next;
      line_count   <= line_count_next;
    end
  end

  // channel unpack, red and blue on the 5-bit scale and green on the 6-bit scale, all in 6-bit fields
  always_comb begin
    alpha = src_pixel[15:12];
    sr    = CHAN_W'({src_pixel[11:8], 1'b0});
    sg    = {src_pixel[7:4], 2'b00};
    sb    = CHAN_W'({src_pixel[3:0], 1'b0});
    dr    = CHAN_W'(dest_pixel[15:11]);
    dg    = dest_pixel[10:5];
    db    = CHAN_W'(dest_pixel[4:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sum_r    <= weigh(sr, dr, alpha);
      s1_sum_g    <= weigh(sg, dg, alpha);
      s1_sum_b    <= weigh(sb, db, alpha);
      s1_dest_row <= ROW_W'(dest_top) + ROW_W'(line_count);
      s1_src_row  <= ROW_W'(src_top) + ROW_W'(line_count);
      s1_dest_col <= ROW_W'(dest_left) + ROW_W'(column_count);
      s1_src_col  <= ROW_W'(src_left) + ROW_W'(column_count);
      s1_last     <= col_end && line_end;
    end
  end

  // second stage: divide by 15 and line base multiply
  always_comb begin
    q_r       = div15(s1_sum_r);
    q_g       = div15(s1_sum_g);
    q_b       = div15(s1_sum_b);
    dest_prod = MUL_W'(s1_dest_row) * MUL_W'(dest_stride);
    src_prod  = MUL_W'(s1_src_row) * MUL_W'(src_stride);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      blended_pixel <= {q_r[4:0], q_g, q_b[4:0]};
      dest_index    <= IDX_W'(dest_prod) + IDX_W'(s1_dest_col);
      src_index     <= IDX_W'(src_prod) + IDX_W'(s1_src_col);
      last          <= s1_last;
    end
  end

  // column restarts after a line end and steps by one otherwise
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    in_acc && col_end |=> column_count == '0)
    else $error("column counter did not restart at line end");

  a_col_step: assert property (@(posedge clk) disable iff (rst)
    in_acc && !col_end |=> column_count == $past(column_count) + CNT_W'(1))
    else $error("column counter did not step");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(column_count) < SIZE_MAX && CMP_W'(line_count) < SIZE_MAX)
    else $error("position counter beyond maximum size");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_en |=> s1_valid && $stable(s1_sum_g) && $stable(s1_last))
    else $error("first stage lost a stalled request");

endmodule
